/* src/axis_vector_rotation_macros.svh */
// Assertion macros shared by the axis vector rotation RTL.
`ifndef AXIS_VECTOR_ROTATION_MACROS_SVH
`define AXIS_VECTOR_ROTATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AVR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AVR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/avr_pkg.sv */
// Types and constants shared by the axis vector rotation modules.
`default_nettype none

package avr_pkg;

  localparam int OP_WIDTH = 2;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_ROT_X = 2'd0,
    OP_ROT_Y = 2'd1,
    OP_ROT_Z = 2'd2,
    OP_PASS  = 2'd3
  } op_e;

  localparam int SINE_W = 15;
  localparam int HORNER_STEPS = 6;
  localparam int QS_LATENCY = 2 * HORNER_STEPS + 4;

  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [14:0] ROUND_HALF = 15'h4000;

  // Exact reciprocals for 32-bit dividends: q / D == (q * MAGIC) >> SHIFT.
  localparam logic [32:0] DIV_MAGIC [HORNER_STEPS] = '{
    33'd7048151461, 33'd4997780127, 33'd7635497416,
    33'd6544712071, 33'd6871947674, 33'd5726623062
  };
  localparam int DIV_SHIFT [HORNER_STEPS] = '{40, 39, 39, 38, 37, 35};

endpackage

`default_nettype wire

/* src/avr_qsine.sv */
// Pipelined quarter-wave sine in unsigned Q0.15 from a Taylor series in Q2.30.
`default_nettype none

module avr_qsine #(
  parameter int AngleWidth = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [AngleWidth-2:0]        phase_i,
  output logic [avr_pkg::SINE_W-1:0]   sine_o
);
  import avr_pkg::*;

  localparam int PhW = AngleWidth - 1;
  localparam int ProdW = PhW + 33;
  localparam int XW = 31;
  localparam int X2W = 32;
  localparam int TW = 31;

  function automatic logic [TW-1:0] horner_term(input logic [X2W-1:0] d);
    logic [TW-1:0] res;
    if (d >= X2W'(ONE_Q30)) begin
      res = '0;
    end else begin
      res = ONE_Q30 - d[TW-1:0];
    end
    return res;
  endfunction

  logic [ProdW-1:0]     phase_prod;
  logic [2*XW-1:0]      sq_prod;
  logic [XW-1:0]        x0_q, x1_q;
  logic [X2W-1:0]       x2_1_q;
  logic [XW-1:0]        x_in   [HORNER_STEPS];
  logic [X2W-1:0]       x2_in  [HORNER_STEPS];
  logic [TW-1:0]        t_in   [HORNER_STEPS];
  logic [X2W+TW-1:0]    prod_a [HORNER_STEPS];
  logic [X2W+32:0]      prod_b [HORNER_STEPS];
  logic [XW-1:0]        xa_q   [HORNER_STEPS];
  logic [X2W-1:0]       x2a_q  [HORNER_STEPS];
  logic [X2W-1:0]       qa_q   [HORNER_STEPS];
  logic [XW-1:0]        xb_q   [HORNER_STEPS];
  logic [X2W-1:0]       x2b_q  [HORNER_STEPS];
  logic [X2W-1:0]       db_q   [HORNER_STEPS];
  logic [XW+TW-1:0]     fin_prod;
  logic [XW-1:0]        v_q;
  logic [X2W-1:0]       v_rnd;
  logic [SINE_W-1:0]    sine_d, sine_q;

  assign phase_prod = ProdW'(phase_i) * ProdW'(TWO_PI_Q30);
  assign sq_prod = (2*XW)'(x0_q) * (2*XW)'(x0_q);

  always_comb begin
    x_in[0]  = x1_q;
    x2_in[0] = x2_1_q;
    t_in[0]  = ONE_Q30;
    for (int i = 1; i < HORNER_STEPS; i++) begin
      x_in[i]  = xb_q[i-1];
      x2_in[i] = x2b_q[i-1];
      t_in[i]  = horner_term(db_q[i-1]);
    end
    for (int i = 0; i < HORNER_STEPS; i++) begin
      prod_a[i] = (X2W+TW)'(x2_in[i]) * (X2W+TW)'(t_in[i]);
      prod_b[i] = (X2W+33)'(qa_q[i]) * (X2W+33)'(DIV_MAGIC[i]);
    end
  end

  assign fin_prod = (XW+TW)'(xb_q[HORNER_STEPS-1]) *
                    (XW+TW)'(horner_term(db_q[HORNER_STEPS-1]));
  assign v_rnd = X2W'(v_q) + X2W'(ROUND_HALF);
  assign sine_d = (v_rnd[X2W-1:X2W-2] != 2'b00) ? {SINE_W{1'b1}} : v_rnd[29:15];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q   <= phase_prod[AngleWidth +: XW];
      x1_q   <= x0_q;
      x2_1_q <= sq_prod[30 +: X2W];
      for (int i = 0; i < HORNER_STEPS; i++) begin
        xa_q[i]  <= x_in[i];
        x2a_q[i] <= x2_in[i];
        qa_q[i]  <= prod_a[i][30 +: X2W];
        xb_q[i]  <= xa_q[i];
        x2b_q[i] <= x2a_q[i];
        db_q[i]  <= X2W'(prod_b[i] >> DIV_SHIFT[i]);
      end
      v_q    <= fin_prod[30 +: XW];
      sine_q <= sine_d;
    end
  end

  assign sine_o = sine_q;

endmodule

`default_nettype wire

/* src/axis_vector_rotation.sv */
// Top level: streaming rotation of a 3-D vector about the X, Y or Z axis.
//
//   Port group   Direction  tdata (low bit up)               tuser
//   s_axis_*     in         in_x, in_y, in_z, angle          operation
//   m_axis_*     out        out_x, out_y, out_z              saturated
//
// One transaction is accepted every cycle while the output is not stalled.
// Results pass the sine and cosine pipelines (two register stages for each
// of the six Horner steps), a product register and the output register.
// Reset clears only the valid bits of the pipeline and the output.
// A result held on the output freezes the whole pipeline and drops
// s_axis_tready_o until the transaction is taken.
`default_nettype none
`include "axis_vector_rotation_macros.svh"

module axis_vector_rotation #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // in_x, in_y, in_z, angle, zero padding
  input  logic [((3*SAMPLE_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // operation
  input  logic [avr_pkg::OP_WIDTH-1:0]             s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  // out_x, out_y, out_z, zero padding
  output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata_o,
  // saturated
  output logic                                     m_axis_tuser_o
);
  import avr_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int OutDataW = ((3*SW+7)/8)*8;
  localparam int PW = SW + 16;
  localparam int SumW = SW + 17;
  localparam int RW = SW + 2;

  typedef struct packed {
    op_e                   op;
    logic [1:0]            quad;
    logic signed [SW-1:0]  x;
    logic signed [SW-1:0]  y;
    logic signed [SW-1:0]  z;
  } item_t;

  logic                   pipe_en;
  item_t                  in_item;
  item_t                  dly_q [QS_LATENCY];
  logic [QS_LATENCY-1:0]  vld_q;
  logic [AW-3:0]          rem;
  logic [AW-2:0]          sin_phase, cos_phase;
  logic [SINE_W-1:0]      sin_r, cos_r;

  item_t                  tail;
  logic signed [15:0]     sr_s, cr_s, s_val, c_val;
  logic signed [SW-1:0]   u_sel, v_sel;
  logic signed [PW-1:0]   cu_d, sv_d, su_d, cv_d;
  logic signed [PW-1:0]   cu_q, sv_q, su_q, cv_q;
  item_t                  r1_q;
  logic                   r1_vld_q;

  logic signed [SumW-1:0] sum_a, sum_b, rs_a, rs_b;
  logic signed [RW-1:0]   rnd_a, rnd_b;
  logic signed [SW-1:0]   sat_a, sat_b;
  logic                   ovf_a, ovf_b;
  logic signed [SW-1:0]   ox_d, oy_d, oz_d;
  logic                   sat_d;
  logic [OutDataW-1:0]    m_tdata_q;
  logic                   m_tuser_q, m_valid_q;
  op_e                    m_op_q;

  assign pipe_en = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = pipe_en;

  assign in_item.op   = op_e'(s_axis_tuser_i);
  assign in_item.x    = s_axis_tdata_i[0 +: SW];
  assign in_item.y    = s_axis_tdata_i[SW +: SW];
  assign in_item.z    = s_axis_tdata_i[2*SW +: SW];
  assign in_item.quad = s_axis_tdata_i[3*SW+AW-2 +: 2];
  assign rem          = s_axis_tdata_i[3*SW +: AW-2];

  assign sin_phase = (AW-1)'(rem);
  assign cos_phase = {1'b1, {(AW-2){1'b0}}} - (AW-1)'(rem);

  avr_qsine #(.AngleWidth(AW)) u_sin (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .phase_i(sin_phase),
    .sine_o (sin_r)
  );

  avr_qsine #(.AngleWidth(AW)) u_cos (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .phase_i(cos_phase),
    .sine_o (cos_r)
  );

  // Quadrant folding of the quarter-wave values into sine and cosine.
  assign tail  = dly_q[QS_LATENCY-1];
  assign sr_s  = $signed({1'b0, sin_r});
  assign cr_s  = $signed({1'b0, cos_r});
  assign s_val = tail.quad[1] ? -(tail.quad[0] ? cr_s : sr_s) : (tail.quad[0] ? cr_s : sr_s);
  assign c_val = (tail.quad[0] ^ tail.quad[1]) ? -(tail.quad[0] ? sr_s : cr_s)
                                               : (tail.quad[0] ? sr_s : cr_s);

  // The rotated pair (u, v) becomes (c*u - s*v, s*u + c*v).
  always_comb begin
    case (tail.op)
      OP_ROT_X: begin
        u_sel = tail.y;
        v_sel = tail.z;
      end
      OP_ROT_Y: begin
        u_sel = tail.z;
        v_sel = tail.x;
      end
      default: begin
        u_sel = tail.x;
        v_sel = tail.y;
      end
    endcase
  end

  assign cu_d = c_val * u_sel;
  assign sv_d = s_val * v_sel;
  assign su_d = s_val * u_sel;
  assign cv_d = c_val * v_sel;

  assign sum_a = SumW'(cu_q) - SumW'(sv_q);
  assign sum_b = SumW'(su_q) + SumW'(cv_q);
  assign rs_a  = sum_a + $signed({{(SumW-15){1'b0}}, ROUND_HALF});
  assign rs_b  = sum_b + $signed({{(SumW-15){1'b0}}, ROUND_HALF});
  assign rnd_a = rs_a[SumW-1:15];
  assign rnd_b = rs_b[SumW-1:15];

  always_comb begin
    ovf_a = (rnd_a[RW-1:SW-1] != {3{rnd_a[RW-1]}});
    ovf_b = (rnd_b[RW-1:SW-1] != {3{rnd_b[RW-1]}});
    sat_a = ovf_a ? {rnd_a[RW-1], {(SW-1){!rnd_a[RW-1]}}} : rnd_a[SW-1:0];
    sat_b = ovf_b ? {rnd_b[RW-1], {(SW-1){!rnd_b[RW-1]}}} : rnd_b[SW-1:0];
    ox_d  = r1_q.x;
    oy_d  = r1_q.y;
    oz_d  = r1_q.z;
    sat_d = ovf_a || ovf_b;
    case (r1_q.op)
      OP_ROT_X: begin
        oy_d = sat_a;
        oz_d = sat_b;
      end
      OP_ROT_Y: begin
        oz_d = sat_a;
        ox_d = sat_b;
      end
      OP_ROT_Z: begin
        ox_d = sat_a;
        oy_d = sat_b;
      end
      default: begin
        sat_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      r1_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (pipe_en) begin
      vld_q     <= {vld_q[QS_LATENCY-2:0], s_axis_tvalid_i};
      r1_vld_q  <= vld_q[QS_LATENCY-1];
      m_valid_q <= r1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dly_q[0] <= in_item;
      for (int i = 1; i < QS_LATENCY; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
      r1_q      <= tail;
      cu_q      <= cu_d;
      sv_q      <= sv_d;
      su_q      <= su_d;
      cv_q      <= cv_d;
      m_tdata_q <= OutDataW'({oz_d, oy_d, ox_d});
      m_tuser_q <= sat_d;
      m_op_q    <= r1_q.op;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

  `AVR_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, vld_q[0], "Accepted transaction did not enter the pipeline.")
  `AVR_ASSERT_NEXT(a_stall_freezes, clk_i, rst_ni, !pipe_en, $stable(vld_q) && $stable(r1_vld_q), "Pipeline moved while the output was stalled.")
  `AVR_ASSERT_IMP(a_pass_no_sat, clk_i, rst_ni, m_valid_q && (m_op_q == OP_PASS), !m_axis_tuser_o, "Pass-through transaction reported saturation.")

endmodule

`default_nettype wire
